// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the queue RTL, used by cfq_ctrl.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low)
`define CFQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("cfq assertion failed");

// Implication form: antecedent leads to consequent in the next cycle
`define CFQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  `CFQ_ASSERT(lbl, clk, rstn, (ante) |=> (cons))

`endif

// ===== hw/rtl/cfq_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfq_pkg
// Types and constants shared by the circular FIFO queue modules.
// ---------------------------------------------------------------------------
package cfq_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned QSIZE_W   = 5;

  localparam logic [QSIZE_W-1:0] QSIZE_RESET = 5'd16;

  // Operation codes carried in the kind field
  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic                     kind;
    logic signed [WORD_W-1:0] push_value;
  } in_req_t;

  typedef struct packed {
    status_t                  status;
    logic signed [WORD_W-1:0] popped_value;
    logic                     now_empty;
    logic                     now_full;
    logic signed [WORD_W-1:0] head_value;
    logic signed [WORD_W-1:0] tail_value;
  } out_rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;  // request taken this cycle
    logic finish;  // dequeue read data is back, load the result
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic deq_ok;  // pending request is a dequeue on a non-empty queue
  } dp_stat_t;

endpackage

// ===== hw/rtl/circular_fifo_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// circular_fifo_queue
// Circular-array FIFO of signed 32-bit words with status per request.
// ---------------------------------------------------------------------------
//  channel  | ports                        | payload
//  ---------+------------------------------+-------------------------------
//  input    | in_valid / in_stall          | in_req  (kind, push_value)
//  result   | out_valid / out_stall        | out_rsp (status ... tail_value)
//  config   | cfg_we                       | cfg_wdata (queue_size)
//
//  An enqueue or a rejected request loads the result register on acceptance;
//  a successful dequeue first waits in S_READ on the registered read of the
//  entry RAM for the new head. One result per request, held in an output register
//  while out_stall is high; a new request is taken while that result leaves.
//  Reset clears the ring indices and sets queue_size to 16; no RAM clearing.
//  A write to queue_size empties the queue, stored words are kept.
// ---------------------------------------------------------------------------
module circular_fifo_queue #(
  parameter int unsigned DEPTH = cfq_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [cfq_pkg::QSIZE_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  cfq_pkg::in_req_t            in_req,
  output logic                        out_valid,
  input  logic                        out_stall,
  output cfq_pkg::out_rsp_t           out_rsp
);

  import cfq_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencer
  cfq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // storage and result formation
  cfq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_req    (in_req),
    .cmd       (cmd),
    .stat      (stat),
    .out_rsp   (out_rsp)
  );

endmodule

// ===== hw/rtl/cfq_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfq_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module cfq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/cfq_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfq_datapath
// Ring indices, cached head/tail words, entry RAM and result register.
// ---------------------------------------------------------------------------
module cfq_datapath #(
  parameter int unsigned DEPTH = cfq_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cfq_pkg::QSIZE_W-1:0]   cfg_wdata,
  input  cfq_pkg::in_req_t              in_req,
  input  cfq_pkg::ctrl_cmd_t            cmd,
  output cfq_pkg::dp_stat_t             stat,
  output cfq_pkg::out_rsp_t             out_rsp
);

  import cfq_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned SW = IW + 1;

  logic [QSIZE_W-1:0] queue_size_r;
  logic [IW-1:0]      head_r, head_nxt;
  logic [IW-1:0]      tail_r, tail_nxt;
  logic [WORD_W-1:0]  head_val_r, head_val_nxt;
  logic [WORD_W-1:0]  tail_val_r, tail_val_nxt;
  logic [WORD_W-1:0]  pop_r;
  out_rsp_t           rsp_r, rsp_nxt;
  logic               rsp_load;

  logic [31:0]        qs_ext;
  logic [SW-1:0]      slots;
  logic               empty_c, full_c;
  logic               enq_ok, deq_ok;
  logic               empty_a, full_a;
  logic               ram_we, ram_re;
  logic [IW-1:0]      ram_raddr;
  logic [WORD_W-1:0]  ram_rdata;

  // next ring slot, wrapping at the active ring size
  function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] i,
                                              input logic [SW-1:0] s);
    logic [SW-1:0] inc;
    inc = {1'b0, i} + SW'(1);
    return (inc == s) ? '0 : inc[IW-1:0];
  endfunction

  // active ring size, clamped to 2..DEPTH
  assign qs_ext = 32'(queue_size_r);
  always_comb begin
    if (qs_ext < 32'd2) begin
      slots = SW'(2);
    end else if (qs_ext > 32'(DEPTH)) begin
      slots = SW'(DEPTH);
    end else begin
      slots = SW'(qs_ext);
    end
  end

  // state before the pending request
  assign empty_c = (head_r == tail_r);
  assign full_c  = (ring_next(tail_r, slots) == head_r);
  assign enq_ok  = (in_req.kind == KIND_ENQ) && !full_c;
  assign deq_ok  = (in_req.kind == KIND_DEQ) && !empty_c;
  assign stat.deq_ok = deq_ok;

  // index and cached word updates
  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    head_val_nxt = head_val_r;
    tail_val_nxt = tail_val_r;
    if (cmd.accept && enq_ok) begin
      tail_nxt     = ring_next(tail_r, slots);
      tail_val_nxt = in_req.push_value;
      if (empty_c) begin
        head_val_nxt = in_req.push_value;
      end
    end
    if (cmd.accept && deq_ok) begin
      head_nxt = ring_next(head_r, slots);
    end
    if (cmd.finish) begin
      head_val_nxt = ram_rdata;
    end
  end

  // flags after an immediate (non-read) request
  assign empty_a = (head_nxt == tail_nxt);
  assign full_a  = (ring_next(tail_nxt, slots) == head_nxt);

  // result formation
  always_comb begin
    rsp_nxt  = rsp_r;
    rsp_load = 1'b0;
    if (cmd.finish) begin
      rsp_load             = 1'b1;
      rsp_nxt.status       = STATUS_DONE;
      rsp_nxt.popped_value = pop_r;
      rsp_nxt.now_empty    = empty_c;
      rsp_nxt.now_full     = full_c;
      rsp_nxt.head_value   = empty_c ? '0 : ram_rdata;
      rsp_nxt.tail_value   = empty_c ? '0 : tail_val_r;
    end else if (cmd.accept && !deq_ok) begin
      rsp_load = 1'b1;
      if (in_req.kind == KIND_ENQ) begin
        rsp_nxt.status = full_c ? STATUS_FULL : STATUS_DONE;
      end else begin
        rsp_nxt.status = STATUS_EMPTY;
      end
      rsp_nxt.popped_value = '0;
      rsp_nxt.now_empty    = empty_a;
      rsp_nxt.now_full     = full_a;
      rsp_nxt.head_value   = empty_a ? '0 : head_val_nxt;
      rsp_nxt.tail_value   = empty_a ? '0 : tail_val_nxt;
    end
  end

  // entry RAM: write on enqueue, fetch the new head on dequeue
  assign ram_we    = cmd.accept && enq_ok;
  assign ram_re    = cmd.accept && deq_ok;
  assign ram_raddr = head_nxt;

  cfq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (in_req.push_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control registers: ring size and indices
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queue_size_r <= QSIZE_RESET;
      head_r       <= '0;
      tail_r       <= '0;
    end else if (cfg_we) begin
      queue_size_r <= cfg_wdata;
      head_r       <= '0;
      tail_r       <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    head_val_r <= head_val_nxt;
    tail_val_r <= tail_val_nxt;
    if (cmd.accept && deq_ok) begin
      pop_r <= head_val_r;
    end
    if (rsp_load) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign out_rsp = rsp_r;

endmodule

// ===== hw/rtl/cfq_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfq_ctrl
// Request sequencer: accepts requests, waits on dequeue reads, owns out_valid.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cfq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  cfq_pkg::dp_stat_t   stat,
  output cfq_pkg::ctrl_cmd_t  cmd
);

  import cfq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   acc;
  logic   load;

  // take a request when idle and the result slot is free or draining
  assign in_stall = !((state_r == S_IDLE) && (!out_valid_r || !out_stall));
  assign acc      = in_valid && !in_stall;

  assign cmd.accept = acc;
  assign cmd.finish = (state_r == S_READ);

  assign load = (acc && !stat.deq_ok) || (state_r == S_READ);

  // state transitions
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc && stat.deq_ok) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // assertions
  `CFQ_ASSERT_NEXT(a_read_one_cycle, clk, rst_n, state_r == S_READ, state_r == S_IDLE)
  `CFQ_ASSERT(a_read_slot_free, clk, rst_n, (state_r == S_READ) |-> !out_valid_r)
  `CFQ_ASSERT_NEXT(a_deq_reads, clk, rst_n, acc && stat.deq_ok, state_r == S_READ)
  `CFQ_ASSERT(a_no_accept_reading, clk, rst_n, (state_r == S_READ) |-> in_stall)

endmodule

// ===== tb/sv/circular_fifo_queue_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// circular_fifo_queue_tb
// Self-checking bench for the circular FIFO queue: a directed table of
// requests and queue_size writes, then random phases of enqueue/dequeue
// traffic with random idling on both channels. Every response is compared
// field by field against a hand-written response or a behavioral model of the ring.
// ---------------------------------------------------------------------------
module circular_fifo_queue_tb;
  import cfq_pkg::*;

  localparam int unsigned DEPTH      = DEPTH_DEF;
  localparam int          RAND_ITEMS = 920;

  // Directed table row types
  typedef enum logic [1:0] {
    ROW_CFG,  // write queue_size
    ROW_REQ,  // request, checked against the model
    ROW_CHK   // request with a hand-written response
  } row_kind_t;

  typedef struct packed {
    row_kind_t        what;
    logic [QSIZE_W-1:0] qsize;
    in_req_t          req;
    out_rsp_t         rsp;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [QSIZE_W-1:0] cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  in_req_t            in_req;
  logic               out_valid;
  logic               out_stall;
  out_rsp_t           out_rsp;

  // Ring model state
  logic signed [WORD_W-1:0] ring_words [DEPTH];
  int unsigned              ring_head;
  int unsigned              ring_tail;
  logic [QSIZE_W-1:0]       ring_qsize;

  out_rsp_t predicted_rsps [$];
  dir_row_t dir_rows [$];

  int  n_errors;
  int  n_checked;
  int  n_full_rej;
  int  n_empty_rej;
  int  n_cfg;
  logic calm;

  circular_fifo_queue i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #(20_000_000);
    $display("timeout with %0d responses outstanding", predicted_rsps.size());
    $display("[circular_fifo_queue] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Ring model
  // ---------------------------------------------------------------------------
  // Ring size in use: register clamped to 2..DEPTH
  function automatic int unsigned ring_slots();
    int unsigned s;
    s = 32'(ring_qsize);
    if (s < 2) s = 2;
    if (s > DEPTH) s = DEPTH;
    return s;
  endfunction

  function automatic void ring_write_qsize(input logic [QSIZE_W-1:0] v);
    ring_qsize = v;
    ring_head  = 0;
    ring_tail  = 0;
  endfunction

  function automatic out_rsp_t predict_queue_step(input in_req_t req);
    out_rsp_t    r;
    int unsigned slots;
    logic        was_empty;
    logic        was_full;
    slots     = ring_slots();
    r         = '0;
    r.status  = STATUS_DONE;
    was_empty = (ring_head == ring_tail);
    was_full  = (((ring_tail + 1) % slots) == ring_head);
    if (req.kind == KIND_ENQ) begin
      if (was_full) begin
        r.status = STATUS_FULL;
      end else begin
        ring_words[ring_tail] = req.push_value;
        ring_tail = (ring_tail + 1) % slots;
      end
    end else begin
      if (was_empty) begin
        r.status = STATUS_EMPTY;
      end else begin
        r.popped_value = ring_words[ring_head];
        ring_head = (ring_head + 1) % slots;
      end
    end
    r.now_empty = (ring_head == ring_tail);
    r.now_full  = (((ring_tail + 1) % slots) == ring_head);
    // head/tail words read as zero on an empty queue
    if (!r.now_empty) begin
      r.head_value = ring_words[ring_head];
      r.tail_value = ring_words[(ring_tail + slots - 1) % slots];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------------
  function automatic out_rsp_t mk_rsp(input status_t st, input logic [WORD_W-1:0] pop,
                                      input logic emp, input logic ful,
                                      input logic [WORD_W-1:0] hd,
                                      input logic [WORD_W-1:0] tl);
    out_rsp_t r;
    r.status       = st;
    r.popped_value = pop;
    r.now_empty    = emp;
    r.now_full     = ful;
    r.head_value   = hd;
    r.tail_value   = tl;
    return r;
  endfunction

  function automatic void add_cfg(input logic [QSIZE_W-1:0] v);
    dir_row_t row;
    row       = '0;
    row.what  = ROW_CFG;
    row.qsize = v;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_req(input logic kind, input logic [WORD_W-1:0] val);
    dir_row_t row;
    row                = '0;
    row.what           = ROW_REQ;
    row.req.kind       = kind;
    row.req.push_value = val;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_chk(input logic kind, input logic [WORD_W-1:0] val,
                                  input out_rsp_t rsp);
    dir_row_t row;
    row                = '0;
    row.what           = ROW_CHK;
    row.req.kind       = kind;
    row.req.push_value = val;
    row.rsp            = rsp;
    dir_rows.push_back(row);
  endfunction

  // Idle length: mostly short, now and then long
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [WORD_W-1:0] corner_word();
    case ($urandom_range(0, 3))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      default: return 32'h7FFF_FFFF;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    n_errors++;
  endtask

  // Drop valid and wait until every response is back
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (predicted_rsps.size() != 0) @(posedge clk);
  endtask

  task automatic write_queue_size(input logic [QSIZE_W-1:0] v);
    hold_until_drained();
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    ring_write_qsize(v);
    n_cfg++;
  endtask

  // Issue one request; called just after a rising edge
  task automatic send_req(input in_req_t req, input logic typed, input out_rsp_t typed_rsp);
    out_rsp_t model_rsp;
    int       gap;
    gap = (calm || $urandom_range(0, 99) < 70) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk); while (in_stall);
    model_rsp = predict_queue_step(req);
    predicted_rsps.push_back(typed ? typed_rsp : model_rsp);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall, then compare against the oldest prediction
  // ---------------------------------------------------------------------------
  initial begin : stall_gen
    int hold;
    hold      = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < 25) begin
        hold = idle_len() - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_results
    out_rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_rsps.size() == 0) begin
        report_mismatch("unexpected response", out_rsp.popped_value, '0);
      end else begin
        want = predicted_rsps.pop_front();
        n_checked++;
        if (out_rsp.status == STATUS_FULL) n_full_rej++;
        if (out_rsp.status == STATUS_EMPTY) n_empty_rej++;
        if (out_rsp.status !== want.status)
          report_mismatch("status", 32'(out_rsp.status), 32'(want.status));
        if (out_rsp.popped_value !== want.popped_value)
          report_mismatch("popped_value", out_rsp.popped_value, want.popped_value);
        if (out_rsp.now_empty !== want.now_empty)
          report_mismatch("now_empty", 32'(out_rsp.now_empty), 32'(want.now_empty));
        if (out_rsp.now_full !== want.now_full)
          report_mismatch("now_full", 32'(out_rsp.now_full), 32'(want.now_full));
        if (out_rsp.head_value !== want.head_value)
          report_mismatch("head_value", out_rsp.head_value, want.head_value);
        if (out_rsp.tail_value !== want.tail_value)
          report_mismatch("tail_value", out_rsp.tail_value, want.tail_value);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    in_req_t            req;
    logic [QSIZE_W-1:0] qs;
    int                 n_rand;
    int                 phase;
    int                 plen;
    int                 pause_at;
    int                 enq_pct;

    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_req    = '0;
    calm      = 1'b0;
    n_errors  = 0;
    n_checked = 0;
    n_full_rej  = 0;
    n_empty_rej = 0;
    n_cfg     = 0;
    n_rand    = 0;
    for (int i = 0; i < DEPTH; i++) ring_words[i] = '0;
    ring_write_qsize(QSIZE_RESET);

    // Directed table: reset state, word extremes, rejects, clamped sizes, wrap
    add_chk(KIND_DEQ, 32'h0, mk_rsp(STATUS_EMPTY, 32'h0, 1'b1, 1'b0, 32'h0, 32'h0));
    add_chk(KIND_ENQ, 32'h7FFF_FFFF,
            mk_rsp(STATUS_DONE, 32'h0, 1'b0, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    add_chk(KIND_ENQ, 32'h8000_0000,
            mk_rsp(STATUS_DONE, 32'h0, 1'b0, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000));
    add_chk(KIND_DEQ, 32'h0,
            mk_rsp(STATUS_DONE, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h8000_0000, 32'h8000_0000));
    add_chk(KIND_DEQ, 32'hFFFF_FFFF,
            mk_rsp(STATUS_DONE, 32'h8000_0000, 1'b1, 1'b0, 32'h0, 32'h0));
    // push_value is don't-care on a dequeue
    add_chk(KIND_DEQ, 32'hFFFF_FFFF, mk_rsp(STATUS_EMPTY, 32'h0, 1'b1, 1'b0, 32'h0, 32'h0));
    // smallest ring: one usable slot
    add_cfg(5'd2);
    add_chk(KIND_ENQ, 32'h0, mk_rsp(STATUS_DONE, 32'h0, 1'b0, 1'b1, 32'h0, 32'h0));
    add_chk(KIND_ENQ, 32'hFFFF_FFFF, mk_rsp(STATUS_FULL, 32'h0, 1'b0, 1'b1, 32'h0, 32'h0));
    add_chk(KIND_DEQ, 32'h0, mk_rsp(STATUS_DONE, 32'h0, 1'b1, 1'b0, 32'h0, 32'h0));
    add_req(KIND_ENQ, 32'h5);
    // size below range clamps to 2; the write also empties the queue
    add_cfg(5'd0);
    add_chk(KIND_DEQ, 32'h0, mk_rsp(STATUS_EMPTY, 32'h0, 1'b1, 1'b0, 32'h0, 32'h0));
    add_req(KIND_ENQ, 32'h1);
    add_chk(KIND_ENQ, 32'h2, mk_rsp(STATUS_FULL, 32'h0, 1'b0, 1'b1, 32'h1, 32'h1));
    add_cfg(5'd1);
    add_req(KIND_ENQ, 32'hA5A5_A5A5);
    add_req(KIND_ENQ, 32'h5A5A_5A5A);
    // three slots: fill, reject, wrap the tail, drain past empty
    add_cfg(5'd3);
    add_req(KIND_ENQ, 32'h11);
    add_req(KIND_ENQ, 32'h22);
    add_req(KIND_ENQ, 32'h33);
    add_req(KIND_DEQ, 32'h0);
    add_req(KIND_ENQ, 32'h44);
    add_req(KIND_DEQ, 32'h0);
    add_req(KIND_DEQ, 32'h0);
    add_req(KIND_DEQ, 32'h0);
    // size above range clamps to DEPTH
    add_cfg(5'd31);
    add_req(KIND_ENQ, 32'h5555_5555);
    add_req(KIND_DEQ, 32'h0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].what == ROW_CFG) begin
        write_queue_size(dir_rows[i].qsize);
      end else begin
        send_req(dir_rows[i].req, dir_rows[i].what == ROW_CHK, dir_rows[i].rsp);
      end
    end

    // Random phases, each with its own ring size and enqueue bias
    phase = 0;
    while (n_rand < RAND_ITEMS) begin
      case ($urandom_range(0, 5))
        0:       qs = 5'd2;
        1, 4:    qs = 5'd16;
        2:       qs = QSIZE_W'($urandom_range(0, 31));
        default: qs = QSIZE_W'($urandom_range(3, 15));
      endcase
      write_queue_size(qs);
      calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0:       enq_pct = 25;
        1:       enq_pct = 50;
        2:       enq_pct = 75;
        default: enq_pct = 90;
      endcase
      plen     = $urandom_range(20, 120);
      pause_at = (phase == 0 || $urandom_range(0, 2) == 0) ? $urandom_range(1, plen - 1) : -1;
      for (int i = 0; i < plen && n_rand < RAND_ITEMS; i++) begin
        if (i == pause_at) hold_until_drained();
        req.kind       = ($urandom_range(0, 99) < enq_pct) ? KIND_ENQ : KIND_DEQ;
        req.push_value = ($urandom_range(0, 9) == 0) ? corner_word() : $urandom;
        send_req(req, 1'b0, '0);
        n_rand++;
      end
      phase++;
    end

    hold_until_drained();
    repeat (20) @(posedge clk);

    $display("checked %0d responses over %0d queue_size writes", n_checked, n_cfg);
    $display("rejects seen: %0d enqueue on full, %0d dequeue on empty",
             n_full_rej, n_empty_rej);
    if (n_errors == 0) begin
      $display("[circular_fifo_queue] OK");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("[circular_fifo_queue] ERROR");
    end
    $finish;
  end

endmodule
